// ----- rtl/esp_pkg.sv -----
// Shared constants for the equal-subset partition checker.
// No dependencies; compiled first.
`default_nettype none

package esp_pkg;

    // Width of one set element on the input channel.
    localparam int VALUE_W = 10;

    // Default width of the running total (sums up to twice the default half bound).
    localparam int TOTAL_W = 11;

endpackage : esp_pkg

`default_nettype wire

// ----- rtl/esp_ifs.sv -----
// Valid/ready channel interfaces for the equal-subset partition checker.
// Depends on esp_pkg.
`default_nettype none

interface esp_in_if;
    logic                        valid;
    logic                        ready;
    logic [esp_pkg::VALUE_W-1:0] value;
    logic                        last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface : esp_in_if

interface esp_out_if #(
    parameter int TOTAL_W = esp_pkg::TOTAL_W
);
    logic               valid;
    logic               ready;
    logic               can_split;
    logic               overflow;
    logic [TOTAL_W-1:0] total;

    modport source (output valid, output can_split, output overflow, output total,
                    input ready);
    modport sink   (input valid, input can_split, input overflow, input total,
                    output ready);
endinterface : esp_out_if

`default_nettype wire

// ----- rtl/esp_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module esp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    output logic [WIDTH-1:0]                       rdata_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                       rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule : esp_ram

`default_nettype wire

// ----- rtl/equal_subset_partition_check.sv -----
// Equal-subset partition checker: top level.
// Depends on esp_pkg, esp_ifs (esp_in_if, esp_out_if) and esp_ram.
//
// Usage:
//   item   - input beats {value, last}; the elements of one set, the final one with last = 1.
//   result - one output beat per set {can_split, overflow, total}, sent after the final
//            element has been folded in.
// The block keeps a bitset of reachable subset sums (0..MAX_HALF) in a small RAM of
// NUM_WORDS words of WORD_BITS bits. Each element is split into a word offset and a bit
// offset by a shared reciprocal-multiply unit, then the bitset is ORed with a
// shifted copy of itself one word per cycle, walking from the top word down so every read
// sees the old contents.
// Each element is accepted, split and then swept word by word, with the sweep also
// covering the RAM read latency. A zero element or one above MAX_HALF skips the sweep.
// After the final element the half-total is split by the same unit and its bit is
// probed through one RAM read.
// item.ready is high only while the sequencer is idle.
// Reset (rst_n low, asynchronous) clears the total, the overflow flag and the per-word
// valid bits, so every word reads as its reset value (only sum zero reachable) without a
// clearing pass. The same happens when a result is loaded.
// The result sits in an output register; a stalled receiver does not block the next set's
// elements, only the loading of the next result.
`default_nettype none

module equal_subset_partition_check #(
    parameter int MAX_HALF  = 1023,
    parameter int WORD_BITS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    esp_in_if.sink     item,
    esp_out_if.source  result
);

    localparam int NUM_WORDS = (MAX_HALF + WORD_BITS) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int KW        = $clog2(NUM_WORDS + 2);
    localparam int SUM_BOUND = 2 * MAX_HALF;
    localparam int TW        = $clog2(SUM_BOUND + 1);
    localparam int SW        = ((TW > esp_pkg::VALUE_W) ? TW : esp_pkg::VALUE_W) + 1;
    localparam int DW        = $clog2(MAX_HALF + 1);
    localparam int RW        = $clog2(WORD_BITS);
    localparam int SHIFT     = DW + RW;
    localparam int MAGIC     = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam int PW        = 2 * DW + 2;
    localparam int TOP_BITS  = MAX_HALF - (NUM_WORDS - 1) * WORD_BITS + 1;
    localparam logic [WORD_BITS-1:0] TOP_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - TOP_BITS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_SPLIT = 6'b000100,
        S_SWEEP = 6'b001000,
        S_PROBE = 6'b010000,
        S_CHECK = 6'b100000
    } state_t;

    // Control state
    state_t                 state_reg,     state_next;
    logic [TW-1:0]          total_reg,     total_next;
    logic                   ovf_reg,       ovf_next;
    logic                   last_reg,      last_next;
    logic                   final_reg,     final_next;
    logic                   active_reg,    active_next;
    logic [KW-1:0]          k_reg,         k_next;
    logic [NUM_WORDS-1:0]   valid_reg,     valid_next;
    logic                   a_ok_reg,      a_ok_next;
    logic [AW-1:0]          a_addr_reg,    a_addr_next;
    logic [AW-1:0]          b_addr_reg,    b_addr_next;
    logic                   out_valid_reg, out_valid_next;

    // Payload
    logic [DW-1:0]          x_reg,         x_next;
    logic [PW-1:0]          prod_reg,      prod_next;
    logic [AW-1:0]          q_reg,         q_next;
    logic [RW-1:0]          r_reg,         r_next;
    logic [WORD_BITS-1:0]   hi_reg,        hi_next;
    logic                   split_reg,     split_next;
    logic                   oflag_reg,     oflag_next;
    logic [TW-1:0]          otot_reg,      otot_next;

    // Datapath
    logic                   item_fire;
    logic                   result_fire;
    logic [SW-1:0]          accum;
    logic [PW-1:0]          quo_full;
    logic [AW-1:0]          split_q;
    logic [DW-1:0]          rem_full;
    logic [RW-1:0]          split_r;
    logic [KW-1:0]          w_full;
    logic [KW-1:0]          a_src;
    logic                   a_ok;
    logic                   ram_we;
    logic [WORD_BITS-1:0]   rdata_a;
    logic [WORD_BITS-1:0]   rdata_b;
    logic [WORD_BITS-1:0]   a_word;
    logic [WORD_BITS-1:0]   b_word;
    logic [2*WORD_BITS-1:0] pair;
    logic [WORD_BITS-1:0]   new_word;
    logic                   load_result;

    assign item.ready       = (state_reg == S_IDLE);
    assign item_fire        = item.valid && item.ready;
    assign result.valid     = out_valid_reg;
    assign result.can_split = split_reg;
    assign result.overflow  = oflag_reg;
    assign result.total     = otot_reg;
    assign result_fire      = out_valid_reg && result.ready;

    // Running total with saturation at the bound
    assign accum = SW'(total_reg) + SW'(item.value);

    // Shared split unit: word offset by reciprocal multiply, bit offset by back-multiply
    assign quo_full = prod_reg >> SHIFT;
    assign split_q  = quo_full[AW-1:0];
    assign rem_full = x_reg - (DW'(split_q) * DW'(WORD_BITS));
    assign split_r  = rem_full[RW-1:0];

    // Sweep addressing: destination word walks down from the top
    assign w_full = KW'(NUM_WORDS) - k_reg;
    assign a_ok   = (w_full > KW'(q_reg));
    assign a_src  = w_full - KW'(q_reg) - KW'(1);

    // Words never written since the last clear read as their reset value
    always_comb
    begin
        if (!a_ok_reg)
        begin
            a_word = '0;
        end
        else if (valid_reg[a_addr_reg])
        begin
            a_word = rdata_a;
        end
        else
        begin
            a_word = (a_addr_reg == '0) ? WORD_BITS'(1) : '0;
        end

        if (valid_reg[b_addr_reg])
        begin
            b_word = rdata_b;
        end
        else
        begin
            b_word = (b_addr_reg == '0) ? WORD_BITS'(1) : '0;
        end
    end

    assign pair     = {hi_reg, a_word} << r_reg;
    assign new_word = (b_word | pair[2*WORD_BITS-1:WORD_BITS]) &
                      ((b_addr_reg == AW'(NUM_WORDS - 1)) ? TOP_MASK : {WORD_BITS{1'b1}});
    assign ram_we   = (state_reg == S_SWEEP) && (k_reg >= KW'(2));
    assign load_result = (state_reg == S_CHECK) && (!out_valid_reg || result.ready);

    esp_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bits (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (b_addr_reg),
        .wdata   (new_word),
        .raddr_a (a_addr_next),
        .rdata_a (rdata_a),
        .raddr_b (b_addr_next),
        .rdata_b (rdata_b)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        final_next     = final_reg;
        active_next    = active_reg;
        k_next         = k_reg;
        valid_next     = valid_reg;
        a_ok_next      = a_ok_reg;
        a_addr_next    = a_addr_reg;
        b_addr_next    = b_addr_reg;
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        prod_next      = prod_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        hi_next        = hi_reg;
        split_next     = split_reg;
        oflag_next     = oflag_reg;
        otot_next      = otot_reg;

        if (result_fire)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    if (accum > SW'(SUM_BOUND))
                    begin
                        total_next = TW'(SUM_BOUND);
                        ovf_next   = 1'b1;
                    end
                    else
                    begin
                        total_next = accum[TW-1:0];
                    end
                    x_next      = DW'(item.value);
                    last_next   = item.last;
                    final_next  = 1'b0;
                    active_next = (item.value != '0) &&
                                  (SW'(item.value) <= SW'(MAX_HALF));
                    state_next  = S_MUL;
                end
            end

            S_MUL:
            begin
                prod_next  = PW'(x_reg) * PW'(MAGIC);
                state_next = S_SPLIT;
            end

            S_SPLIT:
            begin
                q_next = split_q;
                r_next = split_r;
                if (final_reg)
                begin
                    state_next = S_PROBE;
                end
                else if (active_reg)
                begin
                    k_next     = '0;
                    state_next = S_SWEEP;
                end
                else if (last_reg)
                begin
                    // Start the half-total lookup
                    x_next     = DW'(total_reg >> 1);
                    final_next = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_SWEEP:
            begin
                // Issue reads for the next destination word
                a_ok_next   = a_ok;
                a_addr_next = a_ok ? a_src[AW-1:0] : '0;
                b_addr_next = (k_reg == '0) ? '0 : w_full[AW-1:0];
                if (k_reg >= KW'(1))
                begin
                    hi_next = a_word;
                end
                if (ram_we)
                begin
                    valid_next[b_addr_reg] = 1'b1;
                end
                if (k_reg == KW'(NUM_WORDS + 1))
                begin
                    if (last_reg)
                    begin
                        x_next     = DW'(total_reg >> 1);
                        final_next = 1'b1;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end

            S_PROBE:
            begin
                a_ok_next   = 1'b1;
                a_addr_next = q_reg;
                state_next  = S_CHECK;
            end

            S_CHECK:
            begin
                if (load_result)
                begin
                    split_next     = !ovf_reg && !total_reg[0] && a_word[r_reg];
                    oflag_next     = ovf_reg;
                    otot_next      = total_reg;
                    out_valid_next = 1'b1;
                    // Return to the empty-set state
                    valid_next     = '0;
                    total_next     = '0;
                    ovf_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            final_reg     <= 1'b0;
            active_reg    <= 1'b0;
            k_reg         <= '0;
            valid_reg     <= '0;
            a_ok_reg      <= 1'b0;
            a_addr_reg    <= '0;
            b_addr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            final_reg     <= final_next;
            active_reg    <= active_next;
            k_reg         <= k_next;
            valid_reg     <= valid_next;
            a_ok_reg      <= a_ok_next;
            a_addr_reg    <= a_addr_next;
            b_addr_reg    <= b_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        prod_reg  <= prod_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        hi_reg    <= hi_next;
        split_reg <= split_next;
        oflag_reg <= oflag_next;
        otot_reg  <= otot_next;
    end

    // A positive answer needs an even, non-saturated total
    a_split_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.can_split |-> !result.overflow && !result.total[0])
        else $error("can_split set with odd or overflowed total");

    // The running total never passes the bound
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TW'(SUM_BOUND))
        else $error("running total above bound");

    // Loading a result presents it and returns the state to the empty set
    a_clear_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> result.valid && (valid_reg == '0) && (total_reg == '0) && !ovf_reg)
        else $error("state not cleared after result");

endmodule : equal_subset_partition_check

`default_nettype wire
